@@ sv/qts_pkg.sv @@
`timescale 1ns / 1ps
package qts_pkg;

  localparam int DW        = 32;
  localparam int WW        = 64;
  localparam int PW        = 128;
  localparam int RAW       = 5;
  localparam int NREG      = 32;
  localparam int PCW       = 7;
  localparam int CNTW      = 8;
  localparam int STW       = 31;
  localparam int MUL_STEPS = 4;
  localparam int DIV_STEPS = 128;

  typedef enum logic [1:0] {
    OP_MUL = 2'd0,
    OP_DIV = 2'd1,
    OP_ADD = 2'd2,
    OP_END = 2'd3
  } op_t;

  localparam logic [RAW-1:0] R_P0  = 5'd0;
  localparam logic [RAW-1:0] R_V0  = 5'd1;
  localparam logic [RAW-1:0] R_A0  = 5'd2;
  localparam logic [RAW-1:0] R_P1  = 5'd3;
  localparam logic [RAW-1:0] R_V1  = 5'd4;
  localparam logic [RAW-1:0] R_A1  = 5'd5;
  localparam logic [RAW-1:0] R_T   = 5'd6;
  localparam logic [RAW-1:0] R_ST  = 5'd7;
  localparam logic [RAW-1:0] R_T2  = 5'd8;
  localparam logic [RAW-1:0] R_TV0 = 5'd9;
  localparam logic [RAW-1:0] R_TV1 = 5'd10;
  localparam logic [RAW-1:0] R_TA0 = 5'd11;
  localparam logic [RAW-1:0] R_TA1 = 5'd12;
  localparam logic [RAW-1:0] R_D3  = 5'd13;
  localparam logic [RAW-1:0] R_D4  = 5'd14;
  localparam logic [RAW-1:0] R_D5  = 5'd15;
  localparam logic [RAW-1:0] R_S1  = 5'd16;
  localparam logic [RAW-1:0] R_S2  = 5'd17;
  localparam logic [RAW-1:0] R_S3  = 5'd18;
  localparam logic [RAW-1:0] R_S4  = 5'd19;
  localparam logic [RAW-1:0] R_S5  = 5'd20;
  localparam logic [RAW-1:0] R_X   = 5'd21;
  localparam logic [RAW-1:0] R_Y   = 5'd22;
  localparam logic [RAW-1:0] R_Z   = 5'd23;
  localparam logic [RAW-1:0] R_TT  = 5'd24;
  localparam logic [RAW-1:0] R_POS = 5'd25;
  localparam logic [RAW-1:0] R_VEL = 5'd26;
  localparam logic [RAW-1:0] R_ACC = 5'd27;

  typedef struct packed {
    op_t              op;
    logic [RAW-1:0]   ra;
    logic [RAW-1:0]   rb;
    logic             imm_en;
    logic [5:0]       imm;
    logic [5:0]       sh;
    logic [RAW-1:0]   rd;
  } instr_t;

  typedef struct packed {
    logic [DW-1:0] p0;
    logic [DW-1:0] v0;
    logic [DW-1:0] a0;
    logic [DW-1:0] p1;
    logic [DW-1:0] v1;
    logic [DW-1:0] a1;
    logic [DW-1:0] tl;
    logic          invalid;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } qhead_t;

  typedef struct packed {
    logic [WW-1:0] val;
    logic          clip;
  } fm_t;

  typedef struct packed {
    logic [DW-1:0] val;
    logic          clip;
  } fo_t;

  function automatic instr_t mk(input op_t op, input logic [RAW-1:0] ra,
                                input logic [RAW-1:0] rb, input logic imm_en,
                                input int imm, input int sh, input logic [RAW-1:0] rd);
    instr_t i;
    i.op     = op;
    i.ra     = ra;
    i.rb     = rb;
    i.imm_en = imm_en;
    i.imm    = 6'(imm);
    i.sh     = 6'(sh);
    i.rd     = rd;
    return i;
  endfunction

  function automatic instr_t i_mul(input logic [RAW-1:0] ra, input logic [RAW-1:0] rb,
                                   input int sh, input logic [RAW-1:0] rd);
    return mk(OP_MUL, ra, rb, 1'b0, 0, sh, rd);
  endfunction

  function automatic instr_t i_muli(input logic [RAW-1:0] ra, input int imm,
                                    input int sh, input logic [RAW-1:0] rd);
    return mk(OP_MUL, ra, ra, 1'b1, imm, sh, rd);
  endfunction

  function automatic instr_t i_div(input logic [RAW-1:0] ra, input logic [RAW-1:0] rb,
                                   input int sh, input logic [RAW-1:0] rd);
    return mk(OP_DIV, ra, rb, 1'b0, 0, sh, rd);
  endfunction

  function automatic instr_t i_add(input logic [RAW-1:0] ra, input logic [RAW-1:0] rb,
                                   input logic [RAW-1:0] rd);
    return mk(OP_ADD, ra, rb, 1'b0, 0, 0, rd);
  endfunction

  // fit of the boundary conditions, ratio powers, then the three outputs
  function automatic instr_t prog(input logic [PCW-1:0] pc);
    instr_t i;
    i = mk(OP_END, R_P0, R_P0, 1'b0, 0, 0, R_P0);
    case (pc)
      7'd0:  i = i_mul(R_T, R_T, 16, R_T2);
      7'd1:  i = i_mul(R_T, R_V0, 16, R_TV0);
      7'd2:  i = i_mul(R_T, R_V1, 16, R_TV1);
      7'd3:  i = i_mul(R_T2, R_A0, 16, R_TA0);
      7'd4:  i = i_mul(R_T2, R_A1, 16, R_TA1);
      7'd5:  i = i_muli(R_P0, -10, 0, R_X);
      7'd6:  i = i_muli(R_TV0, -6, 0, R_Y);
      7'd7:  i = i_add(R_X, R_Y, R_X);
      7'd8:  i = i_muli(R_P1, 10, 0, R_Y);
      7'd9:  i = i_add(R_X, R_Y, R_X);
      7'd10: i = i_muli(R_TV1, -4, 0, R_Y);
      7'd11: i = i_add(R_X, R_Y, R_X);
      7'd12: i = i_muli(R_TA0, -3, 0, R_Y);
      7'd13: i = i_add(R_TA1, R_Y, R_Y);
      7'd14: i = i_muli(R_Y, 1, 1, R_Y);
      7'd15: i = i_add(R_X, R_Y, R_D3);
      7'd16: i = i_muli(R_P0, 15, 0, R_X);
      7'd17: i = i_muli(R_TV0, 8, 0, R_Y);
      7'd18: i = i_add(R_X, R_Y, R_X);
      7'd19: i = i_muli(R_P1, -15, 0, R_Y);
      7'd20: i = i_add(R_X, R_Y, R_X);
      7'd21: i = i_muli(R_TV1, 7, 0, R_Y);
      7'd22: i = i_add(R_X, R_Y, R_X);
      7'd23: i = i_muli(R_TA0, 3, 0, R_Y);
      7'd24: i = i_muli(R_TA1, -2, 0, R_Z);
      7'd25: i = i_add(R_Y, R_Z, R_Y);
      7'd26: i = i_muli(R_Y, 1, 1, R_Y);
      7'd27: i = i_add(R_X, R_Y, R_D4);
      7'd28: i = i_muli(R_P0, -6, 0, R_X);
      7'd29: i = i_muli(R_TV0, -3, 0, R_Y);
      7'd30: i = i_add(R_X, R_Y, R_X);
      7'd31: i = i_muli(R_P1, 6, 0, R_Y);
      7'd32: i = i_add(R_X, R_Y, R_X);
      7'd33: i = i_muli(R_TV1, -3, 0, R_Y);
      7'd34: i = i_add(R_X, R_Y, R_X);
      7'd35: i = i_muli(R_TA0, -1, 0, R_Y);
      7'd36: i = i_add(R_TA1, R_Y, R_Y);
      7'd37: i = i_muli(R_Y, 1, 1, R_Y);
      7'd38: i = i_add(R_X, R_Y, R_D5);
      7'd39: i = i_div(R_ST, R_T, 32, R_S1);
      7'd40: i = i_mul(R_S1, R_S1, 32, R_S2);
      7'd41: i = i_mul(R_S2, R_S1, 32, R_S3);
      7'd42: i = i_mul(R_S3, R_S1, 32, R_S4);
      7'd43: i = i_mul(R_S4, R_S1, 32, R_S5);
      7'd44: i = i_mul(R_V0, R_ST, 16, R_Y);
      7'd45: i = i_add(R_P0, R_Y, R_POS);
      7'd46: i = i_mul(R_ST, R_ST, 16, R_TT);
      7'd47: i = i_mul(R_A0, R_TT, 17, R_Y);
      7'd48: i = i_add(R_POS, R_Y, R_POS);
      7'd49: i = i_mul(R_S3, R_D3, 32, R_Y);
      7'd50: i = i_add(R_POS, R_Y, R_POS);
      7'd51: i = i_mul(R_S4, R_D4, 32, R_Y);
      7'd52: i = i_add(R_POS, R_Y, R_POS);
      7'd53: i = i_mul(R_S5, R_D5, 32, R_Y);
      7'd54: i = i_add(R_POS, R_Y, R_POS);
      7'd55: i = i_mul(R_S2, R_D3, 32, R_Y);
      7'd56: i = i_muli(R_Y, 3, 0, R_X);
      7'd57: i = i_mul(R_S3, R_D4, 32, R_Y);
      7'd58: i = i_muli(R_Y, 4, 0, R_Y);
      7'd59: i = i_add(R_X, R_Y, R_X);
      7'd60: i = i_mul(R_S4, R_D5, 32, R_Y);
      7'd61: i = i_muli(R_Y, 5, 0, R_Y);
      7'd62: i = i_add(R_X, R_Y, R_X);
      7'd63: i = i_mul(R_A0, R_ST, 16, R_Y);
      7'd64: i = i_add(R_V0, R_Y, R_VEL);
      7'd65: i = i_div(R_X, R_T, 16, R_Y);
      7'd66: i = i_add(R_VEL, R_Y, R_VEL);
      7'd67: i = i_mul(R_S1, R_D3, 32, R_Y);
      7'd68: i = i_muli(R_Y, 6, 0, R_X);
      7'd69: i = i_mul(R_S2, R_D4, 32, R_Y);
      7'd70: i = i_muli(R_Y, 12, 0, R_Y);
      7'd71: i = i_add(R_X, R_Y, R_X);
      7'd72: i = i_mul(R_S3, R_D5, 32, R_Y);
      7'd73: i = i_muli(R_Y, 20, 0, R_Y);
      7'd74: i = i_add(R_X, R_Y, R_X);
      7'd75: i = i_div(R_X, R_T, 16, R_X);
      7'd76: i = i_div(R_X, R_T, 16, R_X);
      7'd77: i = i_add(R_A0, R_X, R_ACC);
      default: i = mk(OP_END, R_P0, R_P0, 1'b0, 0, 0, R_P0);
    endcase
    return i;
  endfunction

  // sign and 128-bit magnitude back to a saturated 64-bit value
  function automatic fm_t from_mag(input logic neg, input logic [PW-1:0] m);
    fm_t r;
    r.clip = 1'b0;
    if (!neg) begin
      if (m[PW-1:WW] != '0 || m[WW-1]) begin
        r.val  = {1'b0, {(WW-1){1'b1}}};
        r.clip = 1'b1;
      end else begin
        r.val = m[WW-1:0];
      end
    end else begin
      if (m[PW-1:WW] != '0 || (m[WW-1] && m[WW-2:0] != '0)) begin
        r.val  = {1'b1, {(WW-1){1'b0}}};
        r.clip = 1'b1;
      end else begin
        r.val = -m[WW-1:0];
      end
    end
    return r;
  endfunction

  function automatic fm_t sadd(input logic [WW-1:0] a, input logic [WW-1:0] b);
    fm_t r;
    logic [WW:0] s;
    s = {a[WW-1], a} + {b[WW-1], b};
    r.clip = s[WW] != s[WW-1];
    if (r.clip) begin
      r.val = s[WW] ? {1'b1, {(WW-1){1'b0}}} : {1'b0, {(WW-1){1'b1}}};
    end else begin
      r.val = s[WW-1:0];
    end
    return r;
  endfunction

  function automatic fo_t clip_dw(input logic [WW-1:0] x);
    fo_t r;
    r.clip = (x[WW-1:DW-1] != '0) && (x[WW-1:DW-1] != '1);
    if (r.clip) begin
      r.val = x[WW-1] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
    end else begin
      r.val = x[DW-1:0];
    end
    return r;
  endfunction

endpackage

@@ sv/qts_ram.sv @@
`timescale 1ns / 1ps
module qts_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ sv/qts_front.sv @@
`timescale 1ns / 1ps
module qts_front import qts_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  logic [DW-1:0] in_start_position,
  input  logic [DW-1:0] in_start_velocity,
  input  logic [DW-1:0] in_start_acceleration,
  input  logic [DW-1:0] in_goal_position,
  input  logic [DW-1:0] in_goal_velocity,
  input  logic [DW-1:0] in_goal_acceleration,
  input  logic [DW-1:0] in_time_left,
  input  logic          pop,
  output qhead_t        head
);

  item_t      q_r [2];
  logic       wp_r, wp_nxt;
  logic       rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;
  item_t      item;

  always_comb begin
    item.p0      = in_start_position;
    item.v0      = in_start_velocity;
    item.a0      = in_start_acceleration;
    item.p1      = in_goal_position;
    item.v1      = in_goal_velocity;
    item.a1      = in_goal_acceleration;
    item.tl      = in_time_left;
    // zero or negative time left goes straight to the goal state
    item.invalid = in_time_left[DW-1] || (in_time_left == '0);
  end

  assign busy = (cnt_r == 2'd2);
  assign push = start && !busy;

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= item;
    end
  end

  assign head.valid = (cnt_r != 2'd0);
  assign head.item  = q_r[rp_r];

endmodule

@@ sv/qts_back.sv @@
`timescale 1ns / 1ps
module qts_back import qts_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  input  qhead_t         head,
  output logic           pop,
  input  logic [STW-1:0] step_time,
  output logic           out_valid,
  output logic [DW-1:0]  out_next_position,
  output logic [DW-1:0]  out_next_velocity,
  output logic [DW-1:0]  out_next_acceleration,
  output logic           out_time_invalid,
  output logic           out_saturated
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_LOAD  = 5'b00010,
    S_FETCH = 5'b00100,
    S_EXEC  = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t          state_r, state_nxt;
  logic [PCW-1:0]  pc_r, pc_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic [2:0]      ld_r, ld_nxt;
  logic [PW-1:0]   prod_r, prod_nxt;
  logic [PW-1:0]   dvd_r, dvd_nxt;
  logic [WW:0]     rem_r, rem_nxt;
  logic            clip_r, clip_nxt;
  logic [WW-1:0]   pos_r, pos_nxt;
  logic [WW-1:0]   vel_r, vel_nxt;
  logic [WW-1:0]   acc_r, acc_nxt;
  logic            ov_r, ov_nxt;
  logic [DW-1:0]   op_r, op_nxt;
  logic [DW-1:0]   ovl_r, ovl_nxt;
  logic [DW-1:0]   oa_r, oa_nxt;
  logic            oti_r, oti_nxt;
  logic            osat_r, osat_nxt;

  instr_t          instr;
  logic [WW-1:0]   rdata_a, rdata_b;
  logic [WW-1:0]   opa, opb, mag_a, mag_b;
  logic            mneg;
  logic [WW-1:0]   pp;
  logic [PW-1:0]   pp_sh;
  logic [PW-1:0]   mshift;
  logic            mrem;
  fm_t             mres, dres, ares;
  logic [WW:0]     r2;
  logic            dge;
  logic [WW-1:0]   ld_data;
  logic            wb_we;
  logic [RAW-1:0]  wb_addr;
  logic [WW-1:0]   wb_data;
  logic            wb_clip;
  fo_t             cp, cv, ca;

  assign instr = prog(pc_r);

  // two copies of the register file give two read ports
  qts_ram #(.WIDTH(WW), .DEPTH(NREG)) u_rf_a (
    .clk(clk), .we(wb_we), .waddr(wb_addr), .wdata(wb_data),
    .raddr(instr.ra), .rdata(rdata_a)
  );

  qts_ram #(.WIDTH(WW), .DEPTH(NREG)) u_rf_b (
    .clk(clk), .we(wb_we), .waddr(wb_addr), .wdata(wb_data),
    .raddr(instr.rb), .rdata(rdata_b)
  );

  always_comb begin
    opa   = rdata_a;
    opb   = instr.imm_en ? {{(WW-6){instr.imm[5]}}, instr.imm} : rdata_b;
    mag_a = opa[WW-1] ? -opa : opa;
    mag_b = opb[WW-1] ? -opb : opb;
    mneg  = opa[WW-1] ^ opb[WW-1];
    // one 32x32 partial product per cycle
    pp    = (cnt_r[1] ? mag_a[WW-1:32] : mag_a[31:0]) *
            (cnt_r[0] ? mag_b[WW-1:32] : mag_b[31:0]);
    pp_sh = {{(PW-WW){1'b0}}, pp} << {(2'(cnt_r[1]) + 2'(cnt_r[0])), 5'b0};
    mshift = prod_r >> instr.sh;
    mrem   = (prod_r & ~({PW{1'b1}} << instr.sh)) != '0;
    mres   = from_mag(mneg, mshift + {{(PW-1){1'b0}}, mneg & mrem});
    r2     = {rem_r[WW-1:0], dvd_r[PW-1]};
    dge    = r2 >= {1'b0, opb};
    dres   = from_mag(opa[WW-1],
                      prod_r + {{(PW-1){1'b0}}, opa[WW-1] & (rem_r != '0)});
    ares   = sadd(opa, opb);
    cp     = clip_dw(pos_r);
    cv     = clip_dw(vel_r);
    ca     = clip_dw(acc_r);
  end

  always_comb begin
    case (ld_r)
      3'd0:    ld_data = {{(WW-DW){head.item.p0[DW-1]}}, head.item.p0};
      3'd1:    ld_data = {{(WW-DW){head.item.v0[DW-1]}}, head.item.v0};
      3'd2:    ld_data = {{(WW-DW){head.item.a0[DW-1]}}, head.item.a0};
      3'd3:    ld_data = {{(WW-DW){head.item.p1[DW-1]}}, head.item.p1};
      3'd4:    ld_data = {{(WW-DW){head.item.v1[DW-1]}}, head.item.v1};
      3'd5:    ld_data = {{(WW-DW){head.item.a1[DW-1]}}, head.item.a1};
      3'd6:    ld_data = {{(WW-DW){head.item.tl[DW-1]}}, head.item.tl};
      default: ld_data = {{(WW-STW){1'b0}}, step_time};
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    pc_nxt    = pc_r;
    cnt_nxt   = cnt_r;
    ld_nxt    = ld_r;
    prod_nxt  = prod_r;
    dvd_nxt   = dvd_r;
    rem_nxt   = rem_r;
    clip_nxt  = clip_r;
    ov_nxt    = 1'b0;
    op_nxt    = op_r;
    ovl_nxt   = ovl_r;
    oa_nxt    = oa_r;
    oti_nxt   = oti_r;
    osat_nxt  = osat_r;
    pop       = 1'b0;
    wb_we     = 1'b0;
    wb_addr   = instr.rd;
    wb_data   = ares.val;
    wb_clip   = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (head.valid) begin
          if (head.item.invalid) begin
            pop      = 1'b1;
            ov_nxt   = 1'b1;
            op_nxt   = head.item.p1;
            ovl_nxt  = head.item.v1;
            oa_nxt   = head.item.a1;
            oti_nxt  = 1'b1;
            osat_nxt = 1'b0;
          end else begin
            state_nxt = S_LOAD;
            ld_nxt    = 3'd0;
            clip_nxt  = 1'b0;
          end
        end
      end
      S_LOAD: begin
        wb_we   = 1'b1;
        wb_addr = {2'b00, ld_r};
        wb_data = ld_data;
        ld_nxt  = ld_r + 3'd1;
        if (ld_r == 3'd7) begin
          pop       = 1'b1;
          pc_nxt    = '0;
          state_nxt = S_FETCH;
        end
      end
      S_FETCH: begin
        cnt_nxt  = '0;
        prod_nxt = '0;
        state_nxt = (instr.op == OP_END) ? S_DONE : S_EXEC;
      end
      S_EXEC: begin
        unique case (instr.op)
          OP_MUL: begin
            if (cnt_r < CNTW'(MUL_STEPS)) begin
              prod_nxt = prod_r + pp_sh;
              cnt_nxt  = cnt_r + CNTW'(1);
            end else begin
              wb_we     = 1'b1;
              wb_data   = mres.val;
              wb_clip   = mres.clip;
              pc_nxt    = pc_r + PCW'(1);
              state_nxt = S_FETCH;
            end
          end
          OP_DIV: begin
            if (cnt_r == '0) begin
              dvd_nxt = {{(PW-WW){1'b0}}, mag_a} << instr.sh;
              rem_nxt = '0;
              cnt_nxt = cnt_r + CNTW'(1);
            end else if (cnt_r <= CNTW'(DIV_STEPS)) begin
              // restoring division, one quotient bit a cycle
              rem_nxt  = dge ? r2 - {1'b0, opb} : r2;
              prod_nxt = {prod_r[PW-2:0], dge};
              dvd_nxt  = {dvd_r[PW-2:0], 1'b0};
              cnt_nxt  = cnt_r + CNTW'(1);
            end else begin
              wb_we     = 1'b1;
              wb_data   = dres.val;
              wb_clip   = dres.clip;
              pc_nxt    = pc_r + PCW'(1);
              state_nxt = S_FETCH;
            end
          end
          OP_ADD: begin
            wb_we     = 1'b1;
            wb_data   = ares.val;
            wb_clip   = ares.clip;
            pc_nxt    = pc_r + PCW'(1);
            state_nxt = S_FETCH;
          end
          OP_END: begin
            state_nxt = S_DONE;
          end
          default: begin
            state_nxt = S_DONE;
          end
        endcase
      end
      S_DONE: begin
        ov_nxt    = 1'b1;
        op_nxt    = cp.val;
        ovl_nxt   = cv.val;
        oa_nxt    = ca.val;
        oti_nxt   = 1'b0;
        osat_nxt  = clip_r | cp.clip | cv.clip | ca.clip;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (wb_clip) begin
      clip_nxt = 1'b1;
    end
  end

  always_comb begin
    pos_nxt = pos_r;
    vel_nxt = vel_r;
    acc_nxt = acc_r;
    if (wb_we && state_r == S_EXEC) begin
      if (wb_addr == R_POS) pos_nxt = wb_data;
      if (wb_addr == R_VEL) vel_nxt = wb_data;
      if (wb_addr == R_ACC) acc_nxt = wb_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pc_r    <= '0;
      cnt_r   <= '0;
      ld_r    <= '0;
      clip_r  <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pc_r    <= pc_nxt;
      cnt_r   <= cnt_nxt;
      ld_r    <= ld_nxt;
      clip_r  <= clip_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    dvd_r  <= dvd_nxt;
    rem_r  <= rem_nxt;
    pos_r  <= pos_nxt;
    vel_r  <= vel_nxt;
    acc_r  <= acc_nxt;
    op_r   <= op_nxt;
    ovl_r  <= ovl_nxt;
    oa_r   <= oa_nxt;
    oti_r  <= oti_nxt;
    osat_r <= osat_nxt;
  end

  assign out_valid             = ov_r;
  assign out_next_position     = op_r;
  assign out_next_velocity     = ovl_r;
  assign out_next_acceleration = oa_r;
  assign out_time_invalid      = oti_r;
  assign out_saturated         = osat_r;

endmodule

@@ sv/quintic_trajectory_step_top.sv @@
`timescale 1ns / 1ps
// One look-ahead step of a quintic trajectory in signed Q16.16. A request is
// taken when start is high and busy is low; a two-entry queue holds requests
// while the arithmetic back end works, and busy rises only when it is full.
// Each result appears for exactly one cycle with out_valid high and cannot be
// held off. A request with time_left not positive returns the goal state in
// the cycle after it reaches the head of the queue with the back end idle. Any
// other request first loads the seven request words and the step time into the
// register file, then runs a fixed program on one shared multiplier that forms
// a 64x64 product from four 32x32 partial products, one radix-2 divider for its
// four divisions and a saturating adder.
// cfg_wdata sets the look-ahead step time; write it only while idle.
module quintic_trajectory_step_top import qts_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  logic [DW-1:0]  in_start_position,
  input  logic [DW-1:0]  in_start_velocity,
  input  logic [DW-1:0]  in_start_acceleration,
  input  logic [DW-1:0]  in_goal_position,
  input  logic [DW-1:0]  in_goal_velocity,
  input  logic [DW-1:0]  in_goal_acceleration,
  input  logic [DW-1:0]  in_time_left,
  input  logic           cfg_we,
  input  logic [STW-1:0] cfg_wdata,
  output logic           out_valid,
  output logic [DW-1:0]  out_next_position,
  output logic [DW-1:0]  out_next_velocity,
  output logic [DW-1:0]  out_next_acceleration,
  output logic           out_time_invalid,
  output logic           out_saturated
);

  logic [STW-1:0] step_time_r, step_time_nxt;
  qhead_t         head;
  logic           pop;

  assign step_time_nxt = cfg_we ? cfg_wdata : step_time_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_time_r <= STW'(655);
    end else begin
      step_time_r <= step_time_nxt;
    end
  end

  qts_front u_front (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .start                 (start),
    .busy                  (busy),
    .in_start_position     (in_start_position),
    .in_start_velocity     (in_start_velocity),
    .in_start_acceleration (in_start_acceleration),
    .in_goal_position      (in_goal_position),
    .in_goal_velocity      (in_goal_velocity),
    .in_goal_acceleration  (in_goal_acceleration),
    .in_time_left          (in_time_left),
    .pop                   (pop),
    .head                  (head)
  );

  qts_back u_back (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .head                  (head),
    .pop                   (pop),
    .step_time             (step_time_r),
    .out_valid             (out_valid),
    .out_next_position     (out_next_position),
    .out_next_velocity     (out_next_velocity),
    .out_next_acceleration (out_next_acceleration),
    .out_time_invalid      (out_time_invalid),
    .out_saturated         (out_saturated)
  );

endmodule

@@ sim/tb_quintic_trajectory_step_top.sv @@
`timescale 1ns / 1ps
module tb_quintic_trajectory_step_top;
  import qts_pkg::*;

  typedef logic signed [63:0] s64_t;

  typedef struct {
    logic [DW-1:0] p0, v0, a0, p1, v1, a1, tl;
  } seg_t;

  typedef struct {
    logic [DW-1:0] pos, vel, acc;
    logic          tinv, sat;
  } look_t;

  typedef struct {
    seg_t  seg;
    bit    typed;
    look_t want;
  } row_t;

  localparam s64_t S64_MAX = 64'sh7fff_ffff_ffff_ffff;
  localparam s64_t S64_MIN = 64'sh8000_0000_0000_0000;
  localparam logic [DW-1:0] W_MAX = 32'h7fff_ffff;
  localparam logic [DW-1:0] W_MIN = 32'h8000_0000;
  localparam logic [DW-1:0] ONE_Q = 32'h0001_0000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  seg_t drv = '{default: '0};
  logic cfg_we = 1'b0;
  logic [STW-1:0] cfg_wdata = '0;
  logic out_valid;
  logic [DW-1:0] o_pos, o_vel, o_acc;
  logic o_tinv, o_sat;

  logic [STW-1:0] step_reg;
  bit             clip_seen;
  look_t          pending_looks[$];
  int             n_taken, n_checked, n_bad, n_invalid_time, n_sat;
  bit             cur_typed;
  look_t          cur_want;

  always #1 clk = ~clk;

  quintic_trajectory_step_top i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_start_position(drv.p0), .in_start_velocity(drv.v0),
    .in_start_acceleration(drv.a0), .in_goal_position(drv.p1),
    .in_goal_velocity(drv.v1), .in_goal_acceleration(drv.a1),
    .in_time_left(drv.tl), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .out_valid(out_valid), .out_next_position(o_pos), .out_next_velocity(o_vel),
    .out_next_acceleration(o_acc), .out_time_invalid(o_tinv), .out_saturated(o_sat)
  );

  function automatic logic [63:0] magn(s64_t x);
    return x < 0 ? 64'(-x) : 64'(x);
  endfunction

  function automatic s64_t back_signed(bit neg, logic [127:0] m);
    if (!neg) begin
      if (m > 128'(S64_MAX)) begin
        clip_seen = 1'b1;
        return S64_MAX;
      end
      return m[63:0];
    end
    if (m > (128'd1 << 63)) begin
      clip_seen = 1'b1;
      return S64_MIN;
    end
    return -m[63:0];
  endfunction

  // floor(a*b / 2^sh)
  function automatic s64_t mul_fl(s64_t a, s64_t b, int sh);
    logic [127:0] p, q;
    bit neg;
    neg = (a < 0) != (b < 0);
    p = {64'd0, magn(a)} * {64'd0, magn(b)};
    q = p >> sh;
    if (neg && (p & ((128'd1 << sh) - 1)) != 0) q = q + 1;
    return back_signed(neg, q);
  endfunction

  // floor(n * 2^sh / d), d positive
  function automatic s64_t div_fl(s64_t n, s64_t d, int sh);
    logic [127:0] num, q, r;
    bit neg;
    neg = n < 0;
    num = {64'd0, magn(n)} << sh;
    q = num / 128'(d);
    r = num % 128'(d);
    if (neg && r != 0) q = q + 1;
    return back_signed(neg, q);
  endfunction

  function automatic s64_t add_sat(s64_t a, s64_t b);
    logic signed [64:0] s;
    s = 65'(a) + 65'(b);
    if (s > 65'(S64_MAX)) begin
      clip_seen = 1'b1;
      return S64_MAX;
    end
    if (s < 65'(S64_MIN)) begin
      clip_seen = 1'b1;
      return S64_MIN;
    end
    return s[63:0];
  endfunction

  function automatic logic [DW-1:0] to_word(s64_t x);
    if (x > 64'sd2147483647) begin
      clip_seen = 1'b1;
      return W_MAX;
    end
    if (x < -64'sd2147483648) begin
      clip_seen = 1'b1;
      return W_MIN;
    end
    return x[DW-1:0];
  endfunction

  function automatic look_t traj_predict(seg_t g);
    s64_t p0, v0, a0, p1, v1, a1, tm, st, tsq, tv0, tv1, ta0, ta1;
    s64_t c3, c4, c5, r1, r2, r3, r4, r5, pos, vel, acc, acc_sum;
    look_t o;
    p0 = $signed(g.p0); v0 = $signed(g.v0); a0 = $signed(g.a0);
    p1 = $signed(g.p1); v1 = $signed(g.v1); a1 = $signed(g.a1);
    tm = $signed(g.tl);
    st = s64_t'(step_reg);
    clip_seen = 1'b0;
    if (tm <= 0) begin
      o.pos = g.p1; o.vel = g.v1; o.acc = g.a1;
      o.tinv = 1'b1; o.sat = 1'b0;
      return o;
    end
    tsq = mul_fl(tm, tm, 16);
    tv0 = mul_fl(tm, v0, 16);
    tv1 = mul_fl(tm, v1, 16);
    ta0 = mul_fl(tsq, a0, 16);
    ta1 = mul_fl(tsq, a1, 16);
    c3 = add_sat(add_sat(add_sat(add_sat(mul_fl(p0, -10, 0), mul_fl(tv0, -6, 0)),
         mul_fl(p1, 10, 0)), mul_fl(tv1, -4, 0)),
         mul_fl(add_sat(ta1, mul_fl(ta0, -3, 0)), 1, 1));
    c4 = add_sat(add_sat(add_sat(add_sat(mul_fl(p0, 15, 0), mul_fl(tv0, 8, 0)),
         mul_fl(p1, -15, 0)), mul_fl(tv1, 7, 0)),
         mul_fl(add_sat(mul_fl(ta0, 3, 0), mul_fl(ta1, -2, 0)), 1, 1));
    c5 = add_sat(add_sat(add_sat(add_sat(mul_fl(p0, -6, 0), mul_fl(tv0, -3, 0)),
         mul_fl(p1, 6, 0)), mul_fl(tv1, -3, 0)),
         mul_fl(add_sat(ta1, mul_fl(ta0, -1, 0)), 1, 1));
    r1 = div_fl(st, tm, 32);
    r2 = mul_fl(r1, r1, 32);
    r3 = mul_fl(r2, r1, 32);
    r4 = mul_fl(r3, r1, 32);
    r5 = mul_fl(r4, r1, 32);
    pos = add_sat(p0, mul_fl(v0, st, 16));
    pos = add_sat(pos, mul_fl(a0, mul_fl(st, st, 16), 17));
    pos = add_sat(pos, mul_fl(r3, c3, 32));
    pos = add_sat(pos, mul_fl(r4, c4, 32));
    pos = add_sat(pos, mul_fl(r5, c5, 32));
    acc_sum = add_sat(add_sat(mul_fl(mul_fl(r2, c3, 32), 3, 0),
              mul_fl(mul_fl(r3, c4, 32), 4, 0)), mul_fl(mul_fl(r4, c5, 32), 5, 0));
    vel = add_sat(add_sat(v0, mul_fl(a0, st, 16)), div_fl(acc_sum, tm, 16));
    acc_sum = add_sat(add_sat(mul_fl(mul_fl(r1, c3, 32), 6, 0),
              mul_fl(mul_fl(r2, c4, 32), 12, 0)), mul_fl(mul_fl(r3, c5, 32), 20, 0));
    acc = add_sat(a0, div_fl(div_fl(acc_sum, tm, 16), tm, 16));
    o.pos = to_word(pos);
    o.vel = to_word(vel);
    o.acc = to_word(acc);
    o.tinv = 1'b0;
    o.sat = clip_seen;
    return o;
  endfunction

  // request accepted and register writes, seen at the rising edge
  always @(posedge clk) begin
    if (rst_n && cfg_we) step_reg <= cfg_wdata;
    if (rst_n && start && !busy) begin
      pending_looks.push_back(cur_typed ? cur_want : traj_predict(drv));
      n_taken++;
    end
  end

  always @(posedge clk) begin
    look_t w;
    if (rst_n && out_valid) begin
      if (pending_looks.size() == 0) begin
        $error("result with nothing pending");
        n_bad++;
      end else begin
        w = pending_looks.pop_front();
        n_checked++;
        if (o_tinv) n_invalid_time++;
        if (o_sat) n_sat++;
        if (o_pos !== w.pos) begin
          $error("next_position: expected %h, got %h", w.pos, o_pos); n_bad++;
        end
        if (o_vel !== w.vel) begin
          $error("next_velocity: expected %h, got %h", w.vel, o_vel); n_bad++;
        end
        if (o_acc !== w.acc) begin
          $error("next_acceleration: expected %h, got %h", w.acc, o_acc); n_bad++;
        end
        if (o_tinv !== w.tinv) begin
          $error("time_invalid: expected %b, got %b", w.tinv, o_tinv); n_bad++;
        end
        if (o_sat !== w.sat) begin
          $error("saturated: expected %b, got %b", w.sat, o_sat); n_bad++;
        end
      end
    end
  end

  task automatic send_request(seg_t g, bit typed, look_t want, int idle_pct);
    int taken_mark;
    if ($urandom_range(99) < idle_pct) repeat ($urandom_range(12, 1)) @(negedge clk);
    drv = g;
    cur_typed = typed;
    cur_want = want;
    start = 1'b1;
    taken_mark = n_taken;
    do @(negedge clk); while (n_taken == taken_mark);
    start = 1'b0;
    cur_typed = 1'b0;
  endtask

  task automatic drain_and_set(logic [STW-1:0] val);
    while (pending_looks.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    cfg_wdata = val;
    cfg_we = 1'b1;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  function automatic logic [DW-1:0] pick_word();
    case ($urandom_range(9))
      0: return W_MAX;
      1: return W_MIN;
      2, 3: return $urandom;
      default: return DW'($signed($urandom_range(2 * 600000)) - 600000);
    endcase
  endfunction

  function automatic seg_t pick_seg();
    seg_t g;
    g.p0 = pick_word(); g.v0 = pick_word(); g.a0 = pick_word();
    g.p1 = pick_word(); g.v1 = pick_word(); g.a1 = pick_word();
    case ($urandom_range(9))
      0: g.tl = DW'(-$signed($urandom_range(ONE_Q * 4)));
      1: g.tl = $urandom;
      2: g.tl = $urandom_range(1, 2000);
      default: g.tl = $urandom_range(ONE_Q / 8, ONE_Q * 20);
    endcase
    return g;
  endfunction

  function automatic row_t mk_row(seg_t g, bit typed, look_t want);
    row_t r;
    r.seg = g; r.typed = typed; r.want = want;
    return r;
  endfunction

  initial begin
    row_t  rows[$];
    seg_t  g;
    look_t none, zero_look;
    int    idle_pct;
    none = '{default: '0};
    zero_look = '{default: '0};
    step_reg = 31'd655;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    // time not positive: goal state comes back, flag raised
    g = '{W_MAX, W_MIN, W_MAX, W_MIN, W_MAX, W_MIN, '0};
    rows.push_back(mk_row(g, 1, '{W_MIN, W_MAX, W_MIN, 1'b1, 1'b0}));
    g = '{W_MIN, W_MAX, W_MIN, W_MAX, W_MIN, W_MAX, W_MIN};
    rows.push_back(mk_row(g, 1, '{W_MAX, W_MIN, W_MAX, 1'b1, 1'b0}));
    g = '{'0, '0, '0, 32'h1234_5678, 32'hfedc_ba98, 32'h0000_0001, 32'hffff_ffff};
    rows.push_back(mk_row(g, 1, '{32'h1234_5678, 32'hfedc_ba98, 32'h1, 1'b1, 1'b0}));
    // at rest with the goal equal to the start: nothing moves
    g = '{'0, '0, '0, '0, '0, '0, ONE_Q};
    rows.push_back(mk_row(g, 1, zero_look));
    g = '{'0, '0, '0, '0, '0, '0, W_MAX};
    rows.push_back(mk_row(g, 1, zero_look));
    // tiny time left gives a huge ratio and saturation; the other rows use larger times
    rows.push_back(mk_row('{'0, '0, '0, ONE_Q, '0, '0, 32'd1}, 0, none));
    rows.push_back(mk_row('{W_MAX, W_MAX, W_MAX, W_MIN, W_MIN, W_MIN, 32'd1}, 0, none));
    rows.push_back(mk_row('{W_MIN, W_MIN, W_MIN, W_MAX, W_MAX, W_MAX, W_MAX}, 0, none));
    rows.push_back(mk_row('{W_MAX, W_MAX, W_MAX, W_MAX, W_MAX, W_MAX, W_MAX}, 0, none));
    rows.push_back(mk_row('{'0, ONE_Q, '0, ONE_Q * 2, ONE_Q, '0, ONE_Q * 2}, 0, none));
    rows.push_back(mk_row('{32'hfff0_0000, 32'h0002_8000, 32'hffff_0000, 32'h0010_0000,
                            '0, '0, 32'h0000_8000}, 0, none));
    foreach (rows[k]) send_request(rows[k].seg, rows[k].typed, rows[k].want, 0);

    // register extremes, zero step time included
    drain_and_set(31'd1);
    foreach (rows[k]) if (!rows[k].typed) send_request(rows[k].seg, 0, none, 0);
    drain_and_set(31'h7fff_ffff);
    foreach (rows[k]) if (!rows[k].typed) send_request(rows[k].seg, 0, none, 0);
    drain_and_set(31'd0);
    foreach (rows[k]) if (!rows[k].typed) send_request(rows[k].seg, 0, none, 0);

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: drain_and_set(31'd655);
        1: drain_and_set(STW'($urandom_range(1, 65536)));
        2: drain_and_set(31'h7fff_ffff);
        3: drain_and_set(31'd1);
        4: drain_and_set(STW'($urandom));
        default: drain_and_set(STW'($urandom_range(100, 20000)));
      endcase
      idle_pct = (ph % 3 == 0) ? 0 : (ph % 3 == 1) ? 72 : 24;
      repeat (300) send_request(pick_seg(), 0, none, idle_pct);
    end

    while (pending_looks.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    $display("sent %0d requests, checked %0d results (%0d with time not positive,",
             n_taken, n_checked, n_invalid_time);
    $display("  %0d saturated) over several step times", n_sat);
    if (n_bad == 0 && pending_looks.size() == 0) begin
      $display("tb_quintic_trajectory_step_top: clean");
    end else begin
      $display("tb_quintic_trajectory_step_top: errors");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("tb_quintic_trajectory_step_top: errors");
    $finish;
  end

endmodule
